FILE: src/assert_macros.svh
// assertion macros shared by the rotation warp rtl
// expects signals named clock and reset in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked check, off while reset is high
`define RWN_ASSERT_CLK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: check failed");

// a stage that is stalled keeps its valid
`define RWN_HOLD(lbl, vld, rdy) \
   `RWN_ASSERT_CLK(lbl, vld && !rdy |=> vld)

`endif

FILE: src/rwn_pkg.sv
// shared constants, types and helpers of the rotation warp block
// no dependencies; used by every rwn module
package rwn_pkg;

   localparam int MAX_WIDTH      = 512;
   localparam int MAX_HEIGHT     = 512;
   localparam int COEF_FRAC_BITS = 14;

   localparam int CW    = 9;                       // coordinate port width
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;                 // frame store address
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int SW    = 10;                      // frame size register width
   localparam int PIXW  = 24;
   localparam int ROWW  = 48;
   localparam int COEFW = 16;
   localparam int DW    = CW + 2;                  // doubled centered coordinate
   localparam int PW    = COEFW + DW;              // one coefficient product
   localparam int NW    = PW + 2;                  // row sum
   localparam int MW    = NW + SW + 1;             // row sum times width
   localparam int QB    = ((XW > YW) ? XW : YW) + 1; // quotient bits
   localparam int SXW   = ((QB > SW) ? QB : SW) + 2; // signed source coordinate
   localparam int DEN_SCALE = 1000;
   localparam int CSR_IW    = 3;

   typedef enum logic [CSR_IW-1:0] {
      CSR_ROT_X  = 3'd0,
      CSR_ROT_Y  = 3'd1,
      CSR_ROT_Z  = 3'd2,
      CSR_WIDTH  = 3'd3,
      CSR_HEIGHT = 3'd4,
      CSR_BYPASS = 3'd5
   } csr_index_type;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [ROWW-1:0] ROT_X_RESET = 48'd16384;
   localparam logic [ROWW-1:0] ROT_Y_RESET = 48'd1073741824;
   localparam logic [ROWW-1:0] ROT_Z_RESET = 48'd70368744177664;
   localparam logic [SW-1:0]   SIZE_RESET  = 10'd512;

   typedef struct packed {
      logic [ROWW-1:0] row_x;
      logic [ROWW-1:0] row_y;
      logic [ROWW-1:0] row_z;
      logic [SW-1:0]   width;
      logic [SW-1:0]   height;
      logic            bypass;
   } cfg_type;

   // per-request sideband carried along the arithmetic pipeline
   typedef struct packed {
      logic            is_read;
      logic [PIXW-1:0] pix;
      logic [AW-1:0]   addr;     // write address or unwarped read address
      logic            direct;   // addr is final, no warp
      logic            black;
      logic [CW-1:0]   cx;
      logic [CW-1:0]   cy;
      logic [SW-1:0]   w;
      logic [SW-1:0]   h;
      logic            negx;
      logic            negy;
   } side_type;

   function automatic logic signed [COEFW-1:0] coef_of(input logic [ROWW-1:0] row,
                                                       input int k);
      coef_of = $signed(row[COEFW*k +: COEFW]);
   endfunction

endpackage

FILE: src/rwn_front.sv
// front pipeline: centering, rotation row products and sums, scaling,
// depth test and sign split ahead of the divider; uses rwn_pkg
module rwn_front (
   input  logic                     clock,
   input  logic                     reset,
   input  rwn_pkg::cfg_type         cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [rwn_pkg::CW-1:0]   req_coord_x,
   input  logic [rwn_pkg::CW-1:0]   req_coord_y,
   input  logic [rwn_pkg::PIXW-1:0] req_pixel_in,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [rwn_pkg::MW-1:0]   mag_x,
   output logic [rwn_pkg::MW-1:0]   mag_y,
   output logic [rwn_pkg::NW-1:0]   den,
   output rwn_pkg::side_type        side
);
   import rwn_pkg::*;

   localparam int NS = 5;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   side_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff;
   side_type s1_in, s4_in, s5_in;

   logic signed [DW-1:0] dx_ff, dy_ff, wd_ff;
   logic signed [DW-1:0] dx_in, dy_in;
   logic signed [PW-1:0] p_ff [3][3];
   logic signed [NW-1:0] n_ff [3];
   logic signed [MW-1:0] nwx_ff, nwy_ff;
   logic [NW-1:0]        d4_ff, d5_ff;
   logic [MW-1:0]        mx_ff, my_ff;

   logic [SW-1:0] w_sat, h_sat;
   logic [CW-1:0] cx_c, cy_c;
   logic          inside_c;

   logic signed [MW-1:0] den_lhs, den_rhs;
   logic                 den_ok;
   logic [MW-1:0]        mx_in, my_in;
   logic                 ov_x, ov_y;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int k = NS-2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign req_ready = en[0];

   // stage 1: frame size clamp and centered doubled coordinates
   always_comb begin
      w_sat = (cfg.width > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : cfg.width;
      h_sat = (cfg.height > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : cfg.height;
      cx_c = CW'(w_sat >> 1);
      cy_c = CW'(h_sat >> 1);
      dx_in = $signed({1'b0, req_coord_x, 1'b0}) - $signed({1'b0, cx_c, 1'b0});
      dy_in = $signed({1'b0, req_coord_y, 1'b0}) - $signed({1'b0, cy_c, 1'b0});
      inside_c = ({1'b0, req_coord_x} < w_sat) && ({1'b0, req_coord_y} < h_sat);
      s1_in.is_read = (req_func == FUNC_READ);
      s1_in.pix = req_pixel_in;
      s1_in.addr = {req_coord_y[YW-1:0], req_coord_x[XW-1:0]};
      s1_in.direct = (req_func == FUNC_WRITE) || cfg.bypass;
      s1_in.black = (req_func == FUNC_READ) && !inside_c;
      s1_in.cx = cx_c;
      s1_in.cy = cy_c;
      s1_in.w = w_sat;
      s1_in.h = h_sat;
      s1_in.negx = 1'b0;
      s1_in.negy = 1'b0;
   end

   // stage 4: scale by width, depth threshold
   always_comb begin
      den_lhs = MW'(n_ff[2]) * MW'(DEN_SCALE);
      den_rhs = $signed(MW'(s3_ff.w) << COEF_FRAC_BITS);
      den_ok = den_lhs > den_rhs;
      s4_in = s3_ff;
      s4_in.black = s3_ff.black || (!s3_ff.direct && !den_ok);
   end

   // stage 5: magnitudes and quotient range check
   always_comb begin
      mx_in = nwx_ff[MW-1] ? MW'(-nwx_ff) : MW'(nwx_ff);
      my_in = nwy_ff[MW-1] ? MW'(-nwy_ff) : MW'(nwy_ff);
      ov_x = (mx_in >> QB) >= MW'(d4_ff);
      ov_y = (my_in >> QB) >= MW'(d4_ff);
      s5_in = s4_ff;
      s5_in.negx = nwx_ff[MW-1];
      s5_in.negy = nwy_ff[MW-1];
      s5_in.black = s4_ff.black || (!s4_ff.direct && (ov_x || ov_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff[0] <= en[0] ? req_valid : v_ff[0];
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff <= s1_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         wd_ff <= $signed({1'b0, w_sat});
      end
      if (en[1]) begin
         s2_ff <= s1_ff;
         for (int r = 0; r < 3; r++) begin
            p_ff[r][0] <= coef_of((r == 0) ? cfg.row_x : (r == 1) ? cfg.row_y : cfg.row_z, 0)
                          * dx_ff;
            p_ff[r][1] <= coef_of((r == 0) ? cfg.row_x : (r == 1) ? cfg.row_y : cfg.row_z, 1)
                          * dy_ff;
            p_ff[r][2] <= coef_of((r == 0) ? cfg.row_x : (r == 1) ? cfg.row_y : cfg.row_z, 2)
                          * wd_ff;
         end
      end
      if (en[2]) begin
         s3_ff <= s2_ff;
         for (int r = 0; r < 3; r++) begin
            n_ff[r] <= NW'(p_ff[r][0]) + NW'(p_ff[r][1]) + NW'(p_ff[r][2]);
         end
      end
      if (en[3]) begin
         s4_ff <= s4_in;
         nwx_ff <= MW'(n_ff[0]) * MW'($signed({1'b0, s3_ff.w}));
         nwy_ff <= MW'(n_ff[1]) * MW'($signed({1'b0, s3_ff.w}));
         d4_ff <= {n_ff[2][NW-2:0], 1'b0};
      end
      if (en[4]) begin
         s5_ff <= s5_in;
         mx_ff <= mx_in;
         my_ff <= my_in;
         d5_ff <= d4_ff;
      end
   end

   assign out_valid = v_ff[NS-1];
   assign mag_x = mx_ff;
   assign mag_y = my_ff;
   assign den = d5_ff;
   assign side = s5_ff;

endmodule

FILE: src/rwn_div.sv
// pipelined restoring divider, one quotient bit per stage, two lanes
// sharing one divisor; uses rwn_pkg
module rwn_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [rwn_pkg::MW-1:0] in_mag_x,
   input  logic [rwn_pkg::MW-1:0] in_mag_y,
   input  logic [rwn_pkg::NW-1:0] in_den,
   input  rwn_pkg::side_type      in_side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [rwn_pkg::QB-1:0] q_x,
   output logic [rwn_pkg::QB-1:0] q_y,
   output rwn_pkg::side_type      out_side
);
   import rwn_pkg::*;

   logic [QB-1:0] v_ff;
   logic [QB-1:0] en;

   logic [MW-1:0] rx_ff [QB];
   logic [MW-1:0] ry_ff [QB];
   logic [QB-1:0] qx_ff [QB];
   logic [QB-1:0] qy_ff [QB];
   logic [NW-1:0] d_ff  [QB];
   side_type      sd_ff [QB];

   logic [MW-1:0] srx [QB];
   logic [MW-1:0] sry [QB];
   logic [QB-1:0] sqx [QB];
   logic [QB-1:0] sqy [QB];
   logic [NW-1:0] sd  [QB];
   logic [MW-1:0] rx_in [QB];
   logic [MW-1:0] ry_in [QB];
   logic [QB-1:0] qx_in [QB];
   logic [QB-1:0] qy_in [QB];
   logic [MW:0]   trial [QB];
   logic          gex, gey;

   always_comb begin
      en[QB-1] = !v_ff[QB-1] || out_ready;
      for (int k = QB-2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign in_ready = en[0];

   always_comb begin
      srx[0] = in_mag_x;
      sry[0] = in_mag_y;
      sqx[0] = '0;
      sqy[0] = '0;
      sd[0]  = in_den;
      for (int k = 1; k < QB; k++) begin
         srx[k] = rx_ff[k-1];
         sry[k] = ry_ff[k-1];
         sqx[k] = qx_ff[k-1];
         sqy[k] = qy_ff[k-1];
         sd[k]  = d_ff[k-1];
      end
      for (int k = 0; k < QB; k++) begin
         // stage k resolves quotient bit QB-1-k
         trial[k] = {{(MW+1-NW){1'b0}}, sd[k]} << (QB-1-k);
         gex = {1'b0, srx[k]} >= trial[k];
         gey = {1'b0, sry[k]} >= trial[k];
         rx_in[k] = gex ? (srx[k] - trial[k][MW-1:0]) : srx[k];
         ry_in[k] = gey ? (sry[k] - trial[k][MW-1:0]) : sry[k];
         qx_in[k] = sqx[k];
         qy_in[k] = sqy[k];
         qx_in[k][QB-1-k] = gex;
         qy_in[k][QB-1-k] = gey;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff[0] <= en[0] ? in_valid : v_ff[0];
         for (int k = 1; k < QB; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QB; k++) begin
         if (en[k]) begin
            rx_ff[k] <= rx_in[k];
            ry_ff[k] <= ry_in[k];
            qx_ff[k] <= qx_in[k];
            qy_ff[k] <= qy_in[k];
            d_ff[k]  <= sd[k];
            sd_ff[k] <= (k == 0) ? in_side : sd_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign out_valid = v_ff[QB-1];
   assign q_x = qx_ff[QB-1];
   assign q_y = qy_ff[QB-1];
   assign out_side = sd_ff[QB-1];

endmodule

FILE: src/rwn_store.sv
// source address build, frame store memory and response register
// uses rwn_pkg; fed by the divider
module rwn_store (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [rwn_pkg::QB-1:0]   q_x,
   input  logic [rwn_pkg::QB-1:0]   q_y,
   input  rwn_pkg::side_type        in_side,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [rwn_pkg::PIXW-1:0] rsp_pixel_out
);
   import rwn_pkg::*;

   logic            s6_v_ff;
   logic            s6_read_ff;
   logic            s6_black_ff;
   logic [AW-1:0]   s6_addr_ff;
   logic [PIXW-1:0] s6_pix_ff;
   logic            o_v_ff;
   logic            o_black_ff;
   logic [PIXW-1:0] rd_ff;
   logic [PIXW-1:0] store_ff [DEPTH];

   logic en6, en_o, move;
   logic signed [SXW-1:0] ox, oy, sx, sy;
   logic          in_x, in_y;
   logic [AW-1:0] addr_in;
   logic          black_in;

   assign en_o = !o_v_ff || rsp_ready;
   assign en6 = !s6_v_ff || en_o;
   assign in_ready = en6;
   assign move = s6_v_ff && en_o;

   always_comb begin
      ox = in_side.negx ? -$signed(SXW'(q_x)) : $signed(SXW'(q_x));
      oy = in_side.negy ? -$signed(SXW'(q_y)) : $signed(SXW'(q_y));
      sx = $signed(SXW'(in_side.cx)) + ox;
      sy = $signed(SXW'(in_side.cy)) + oy;
      in_x = !sx[SXW-1] && (sx < $signed(SXW'(in_side.w)));
      in_y = !sy[SXW-1] && (sy < $signed(SXW'(in_side.h)));
      addr_in = in_side.direct ? in_side.addr : {sy[YW-1:0], sx[XW-1:0]};
      black_in = in_side.black || (!in_side.direct && !(in_x && in_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (en6) begin
            s6_v_ff <= in_valid;
         end
         if (en_o) begin
            o_v_ff <= s6_v_ff && s6_read_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         s6_read_ff <= in_side.is_read;
         s6_black_ff <= black_in;
         s6_addr_ff <= addr_in;
         s6_pix_ff <= in_side.pix;
      end
      if (move) begin
         o_black_ff <= s6_black_ff;
      end
   end

   // writes and reads reach the memory in request order
   always_ff @(posedge clock) begin
      if (move) begin
         if (!s6_read_ff) begin
            store_ff[s6_addr_ff] <= s6_pix_ff;
         end else begin
            rd_ff <= store_ff[s6_addr_ff];
         end
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_pixel_out = o_black_ff ? '0 : rd_ff;

endmodule

FILE: src/rotation_warp_nearest.sv
// Rotation-compensating image warp with nearest-neighbor sampling.
// Request channel (req_*): func 0 stores req_pixel_in at (coord_x, coord_y),
// func 1 asks for the warped pixel at that destination. Only reads respond.
// Response channel (rsp_*): one pixel per read, in request order, zero when black.
// Register port (csr_*): index 0..5 = rot_row_x, rot_row_y, rot_row_z,
// frame_width, frame_height, bypass; always ready, unknown indexes dropped.
// Throughput: one request per clock while rsp_ready does not stall the pipeline. A read
// result passes 5 arithmetic stages, 10 divider stages of one quotient bit each,
// the address stage and the frame store read.
// Writes travel the same pipeline and update the store in request order.
// Reset clears the pipeline and loads identity rows, 512x512 and bypass on;
// the frame store is not cleared and must be written before it is read.
// When rsp_ready is low, bubbles are squeezed out and requests keep being
// taken until every stage holds one; then req_ready falls.
// Depends on rwn_pkg, rwn_front, rwn_div, rwn_store and assert_macros.svh.
`include "assert_macros.svh"
module rotation_warp_nearest (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [rwn_pkg::CW-1:0]     req_coord_x,
   input  logic [rwn_pkg::CW-1:0]     req_coord_y,
   input  logic [rwn_pkg::PIXW-1:0]   req_pixel_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rwn_pkg::PIXW-1:0]   rsp_pixel_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rwn_pkg::CSR_IW-1:0] csr_index,
   input  logic [rwn_pkg::ROWW-1:0]   csr_data
);
   import rwn_pkg::*;

   cfg_type cfg_ff;

   logic          front_valid, front_ready;
   logic [MW-1:0] front_mx, front_my;
   logic [NW-1:0] front_den;
   side_type      front_side;
   logic          div_valid, div_ready;
   logic [QB-1:0] div_qx, div_qy;
   side_type      div_side;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_x <= ROT_X_RESET;
         cfg_ff.row_y <= ROT_Y_RESET;
         cfg_ff.row_z <= ROT_Z_RESET;
         cfg_ff.width <= SIZE_RESET;
         cfg_ff.height <= SIZE_RESET;
         cfg_ff.bypass <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROT_X: begin
               cfg_ff.row_x <= csr_data;
            end
            CSR_ROT_Y: begin
               cfg_ff.row_y <= csr_data;
            end
            CSR_ROT_Z: begin
               cfg_ff.row_z <= csr_data;
            end
            CSR_WIDTH: begin
               cfg_ff.width <= csr_data[SW-1:0];
            end
            CSR_HEIGHT: begin
               cfg_ff.height <= csr_data[SW-1:0];
            end
            CSR_BYPASS: begin
               cfg_ff.bypass <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   rwn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_pixel_in (req_pixel_in),
      .out_valid    (front_valid),
      .out_ready    (front_ready),
      .mag_x        (front_mx),
      .mag_y        (front_my),
      .den          (front_den),
      .side         (front_side)
   );

   rwn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_mag_x  (front_mx),
      .in_mag_y  (front_my),
      .in_den    (front_den),
      .in_side   (front_side),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .q_x       (div_qx),
      .q_y       (div_qy),
      .out_side  (div_side)
   );

   rwn_store u_store (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (div_valid),
      .in_ready      (div_ready),
      .q_x           (div_qx),
      .q_y           (div_qy),
      .in_side       (div_side),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out)
   );

   `RWN_HOLD(a_front_hold, front_valid, front_ready)
   `RWN_HOLD(a_div_hold, div_valid, div_ready)
   `RWN_ASSERT_CLK(a_div_payload, div_valid && !div_ready |=> $stable(div_qx) && $stable(div_qy))

endmodule
